// ===== sv/wpso_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpso_pkg
// Shared types, constants and codes for the wheel pulse speed / odometer block.
// ----------------------------------------------------------------------------
package wpso_pkg;

    // Ring depth default
    localparam int WINDOW_DEF = 5;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int COEF_W  = 16;
    localparam int SPEED_W = 8;
    localparam int DIST_W  = 32;
    localparam int SPIKE_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Shared serial divider
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int STEP_W    = $clog2(DIV_NUM_W + 1);

    // Arithmetic constants
    localparam int unsigned SPEED_NUM   = 72000000;  // 3600 s/h * 1e6 / 50 us
    localparam int          SPEED_BITS  = 27;        // SPEED_NUM < 2**27
    localparam int          DIST_SCALE  = 100;       // 0.01 km per km
    localparam int          DIST_BITS   = 39;        // 32-bit count times 100
    localparam int          PULSE_DIV   = 50;        // odometer gathers more than coef/50 pulses
    localparam int          CMP_W       = 38;        // 32-bit count times 50
    localparam int          SPIKE_DELTA = 50;
    localparam int          SPIKE_LIMIT = 100;

    // Register reset values
    localparam logic [COEF_W-1:0] COEF_RST      = 16'd7200;
    localparam logic [TICK_W-1:0] MIN_WIDTH_RST = 16'd39;
    localparam logic              TEST_MODE_RST = 1'b0;
    localparam logic [DIST_W-1:0] PRESET_RST    = 32'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_COEF      = 2'd0,
        REG_MIN_WIDTH       = 2'd1,
        REG_TEST_MODE       = 2'd2,
        REG_DISTANCE_PRESET = 2'd3
    } cfg_reg_t;

    // Input action codes
    localparam logic ACT_PULSE   = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIST_GO,
        ST_DIST_WAIT,
        ST_SCAN,
        ST_TRIM,
        ST_TRIM_WAIT,
        ST_MUL,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_OUT
    } state_t;

    // Divider request
    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    steps;   // quotient bits to produce
        logic [DIV_NUM_W-1:0] num;     // left aligned numerator
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    // Ring control
    typedef struct packed {
        logic clr;
        logic we;
    } ring_ctrl_t;

endpackage

// ===== sv/wpso_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpso_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module wpso_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wpso_pkg::div_req_t                   req,
    output logic                                 done,
    output logic [wpso_pkg::DIV_NUM_W-1:0]       quo
);
    import wpso_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out at the top, quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/wpso_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpso_ring
// Interval ring: one write port, one read port, clear of all entries at once.
// ----------------------------------------------------------------------------
module wpso_ring #(
    parameter int WINDOW = wpso_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wpso_pkg::ring_ctrl_t          ctrl,
    input  logic [$clog2(WINDOW)-1:0]     wr_idx,
    input  logic [wpso_pkg::TICK_W-1:0]   wr_data,
    input  logic [$clog2(WINDOW)-1:0]     rd_idx,
    output logic [wpso_pkg::TICK_W-1:0]   rd_data
);
    import wpso_pkg::*;

    logic [TICK_W-1:0] ring_reg [WINDOW];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else if (ctrl.we) begin
            ring_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = ring_reg[rd_idx];

endmodule

// ===== sv/wheel_pulse_speed_odometer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_pulse_speed_odometer
// Speed and odometer from wheel sensor pulse intervals, one shared divider.
// ----------------------------------------------------------------------------
// Each input beat is a sensor pulse (with its interval in 50 us ticks) or a
// timer timeout, and gives exactly one result beat with the filtered speed in
// km/h, the odometer in 0.01 km and a glitch flag. Items are processed one at
// a time under a small sequencer that drives a single one-bit-per-cycle
// divider: a timeout goes straight to the result; a pulse may first run
// the distance division when the odometer rolls whole units forward, then
// scans the ring and forms the trimmed mean through a reciprocal multiply
// (test mode takes one entry instead) before the speed division, which a
// zero mean skips. The divider produces 27 quotient bits for the speed and
// 39 for the distance step. A finished result sits in an output register,
// so the next beat is taken while it waits. Configuration writes through
// cfg_we must be made only while no item is in flight; the block does not
// enforce this. A distance preset write also loads the odometer at once.
// ----------------------------------------------------------------------------
module wheel_pulse_speed_odometer #(
    parameter int WINDOW = wpso_pkg::WINDOW_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [wpso_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wpso_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [wpso_pkg::TICK_W-1:0]        s_interval_ticks,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [wpso_pkg::SPEED_W-1:0]       m_instant_speed,
    output logic [wpso_pkg::DIST_W-1:0]        m_total_distance,
    output logic                               m_glitch
);
    import wpso_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = TICK_W + $clog2(WINDOW);

    // trimmed mean: floor(x / (WINDOW-2)) as (x * ceil(2^k / d)) >> k, exact for x < 2^SUM_W
    localparam int TRIM_DIV = WINDOW - 2;
    localparam int TRIM_SH  = SUM_W + $clog2(TRIM_DIV);
    localparam int TRIM_M_W = TRIM_SH + 1;
    localparam int TRIM_P_W = SUM_W + TRIM_M_W;
    localparam logic [TRIM_M_W-1:0] TRIM_RECIP =
        TRIM_M_W'(((longint'(1) << TRIM_SH) + longint'(TRIM_DIV - 1)) / longint'(TRIM_DIV));

    // configuration
    logic [COEF_W-1:0] coef_reg;
    logic [TICK_W-1:0] min_width_reg;
    logic              test_mode_reg;
    logic [COEF_W-1:0] coef_nz;

    // sequencer
    state_t state_reg, state_next;

    // block state
    logic              armed_reg, armed_next;
    logic [IDX_W-1:0]  ring_index_reg, ring_index_next;
    logic [DIST_W-1:0] pending_reg, pending_next;
    logic [DIST_W-1:0] distance_reg, distance_next;
    logic [SPEED_W-1:0] speed_now_reg, speed_now_next;
    logic [SPEED_W-1:0] speed_last_reg, speed_last_next;
    logic [SPIKE_W-1:0] spike_reg, spike_next;

    // item work registers
    logic              act_reg, act_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              glitch_reg, glitch_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [TICK_W-1:0] lo_reg, lo_next;
    logic [TICK_W-1:0] hi_reg, hi_next;
    logic [TICK_W-1:0] w_reg, w_next;
    logic [DIV_DEN_W-1:0] prod_reg, prod_next;

    // output register
    logic               m_valid_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_glitch_reg;
    logic               out_load;

    // datapath helpers
    logic [DIST_W-1:0] p1;
    logic              accept_w;
    logic              dist_hit;
    logic [IDX_W-1:0]  idx_adv;
    logic [SUM_W-1:0]  trimmed;
    logic [TRIM_P_W-1:0] trim_prod;
    logic [SPEED_W-1:0] s_new;
    logic [SPEED_W-1:0] s_diff;
    logic [SPIKE_W-1:0] spike_inc;
    logic              is_spike;

    // unit connections
    div_req_t             div_req;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    ring_ctrl_t           ring_ctrl;
    logic [IDX_W-1:0]     ring_wr_idx;
    logic [TICK_W-1:0]    ring_rd_data;

    assign coef_nz  = (coef_reg == '0) ? COEF_W'(1) : coef_reg;
    assign p1       = pending_reg + 1'b1;
    assign accept_w = ticks_reg >= min_width_reg;
    // pending > floor(coef/50)  <=>  50 * pending > coef
    assign dist_hit = (CMP_W'(p1) * CMP_W'(PULSE_DIV)) > CMP_W'(coef_nz);
    assign idx_adv  = (ring_index_reg == IDX_W'(WINDOW - 1)) ? '0 : ring_index_reg + 1'b1;
    assign trimmed  = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
    assign trim_prod = TRIM_P_W'(sum_reg) * TRIM_P_W'(TRIM_RECIP);
    assign s_new    = div_quo[SPEED_W-1:0];
    assign s_diff   = s_new - speed_last_reg;
    assign spike_inc = spike_reg + 1'b1;
    assign is_spike = (s_new > speed_last_reg) && (s_diff >= SPEED_W'(SPIKE_DELTA));
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    wpso_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    wpso_ring #(
        .WINDOW (WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .wr_idx  (ring_wr_idx),
        .wr_data (ticks_reg),
        .rd_idx  (scan_reg),
        .rd_data (ring_rd_data)
    );

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (act_reg == ACT_TIMEOUT) begin
                    state_next = ST_OUT;
                end else if (armed_reg && accept_w && dist_hit) begin
                    state_next = ST_DIST_GO;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_DIST_GO:   state_next = ST_DIST_WAIT;
            ST_DIST_WAIT: begin
                if (div_done) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (test_mode_reg || scan_reg == IDX_W'(WINDOW - 1)) begin
                    state_next = test_mode_reg ? ST_MUL : ST_TRIM;
                end
            end
            ST_TRIM:      state_next = ST_TRIM_WAIT;
            ST_TRIM_WAIT: state_next = ST_MUL;
            ST_MUL:       state_next = (w_reg == '0) ? ST_OUT : ST_SPD_GO;
            ST_SPD_GO:    state_next = ST_SPD_WAIT;
            ST_SPD_WAIT: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- unit controls ----------------
    always_comb begin
        s_ready       = 1'b0;
        ring_ctrl.clr = 1'b0;
        ring_ctrl.we  = 1'b0;
        ring_wr_idx   = test_mode_reg ? '0 : idx_adv;
        div_req.start = 1'b0;
        div_req.steps = STEP_W'(SPEED_BITS);
        div_req.num   = DIV_NUM_W'(SPEED_NUM) << (DIV_NUM_W - SPEED_BITS);
        div_req.den   = prod_reg;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EVAL: begin
                ring_ctrl.clr = (act_reg == ACT_TIMEOUT);
                ring_ctrl.we  = (act_reg == ACT_PULSE) && armed_reg && accept_w;
            end
            ST_DIST_GO: begin
                div_req.start = 1'b1;
                div_req.steps = STEP_W'(DIST_BITS);
                div_req.num   = DIV_NUM_W'(DIV_NUM_W'(pending_reg) * DIV_NUM_W'(DIST_SCALE))
                                << (DIV_NUM_W - DIST_BITS);
                div_req.den   = DIV_DEN_W'(coef_nz);
            end
            ST_SPD_GO: div_req.start = 1'b1;
            default: ;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        armed_next      = armed_reg;
        ring_index_next = ring_index_reg;
        pending_next    = pending_reg;
        distance_next   = distance_reg;
        speed_now_next  = speed_now_reg;
        speed_last_next = speed_last_reg;
        spike_next      = spike_reg;
        act_next        = act_reg;
        ticks_next      = ticks_reg;
        glitch_next     = glitch_reg;
        scan_next       = scan_reg;
        sum_next        = sum_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        w_next          = w_reg;
        prod_next       = prod_reg;

        unique case (state_reg)
            ST_IDLE: begin
                act_next   = s_action;
                ticks_next = s_interval_ticks;
            end
            ST_EVAL: begin
                glitch_next = 1'b0;
                scan_next   = '0;
                sum_next    = '0;
                lo_next     = '1;
                hi_next     = '0;
                if (act_reg == ACT_TIMEOUT) begin
                    armed_next      = 1'b0;
                    speed_now_next  = '0;
                    speed_last_next = '0;
                    ring_index_next = '0;
                end else if (!armed_reg) begin
                    armed_next   = 1'b1;
                    pending_next = p1;
                end else if (accept_w) begin
                    pending_next = p1;
                    if (!test_mode_reg) begin
                        ring_index_next = idx_adv;
                    end
                end else begin
                    glitch_next = 1'b1;
                end
            end
            ST_DIST_GO: pending_next = '0;
            ST_DIST_WAIT: begin
                if (div_done) begin
                    distance_next = distance_reg + div_quo[DIST_W-1:0];
                end
            end
            ST_SCAN: begin
                if (test_mode_reg) begin
                    w_next = ring_rd_data;   // scan index is still zero
                end else begin
                    sum_next  = sum_reg + SUM_W'(ring_rd_data);
                    lo_next   = (ring_rd_data < lo_reg) ? ring_rd_data : lo_reg;
                    hi_next   = (ring_rd_data > hi_reg) ? ring_rd_data : hi_reg;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_TRIM:      sum_next = trimmed;
            ST_TRIM_WAIT: w_next = trim_prod[TRIM_SH +: TICK_W];
            ST_MUL: prod_next = DIV_DEN_W'(w_reg) * DIV_DEN_W'(coef_nz);
            ST_SPD_WAIT: begin
                if (div_done) begin
                    if (test_mode_reg) begin
                        speed_now_next  = s_new;
                        speed_last_next = s_new;
                    end else if (is_spike) begin
                        // large rise must repeat before it is believed
                        if (spike_inc >= SPIKE_W'(SPIKE_LIMIT)) begin
                            spike_next      = '0;
                            speed_now_next  = s_new;
                            speed_last_next = s_new;
                        end else begin
                            spike_next = spike_inc;
                        end
                    end else begin
                        spike_next      = '0;
                        speed_now_next  = s_new;
                        speed_last_next = s_new;
                    end
                end
            end
            default: ;
        endcase

        if (cfg_we && cfg_index == REG_DISTANCE_PRESET) begin
            distance_next = cfg_wdata[DIST_W-1:0];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            coef_reg       <= COEF_RST;
            min_width_reg  <= MIN_WIDTH_RST;
            test_mode_reg  <= TEST_MODE_RST;
            armed_reg      <= 1'b0;
            ring_index_reg <= '0;
            pending_reg    <= '0;
            distance_reg   <= PRESET_RST;
            speed_now_reg  <= '0;
            speed_last_reg <= '0;
            spike_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            armed_reg      <= armed_next;
            ring_index_reg <= ring_index_next;
            pending_reg    <= pending_next;
            distance_reg   <= distance_next;
            speed_now_reg  <= speed_now_next;
            speed_last_reg <= speed_last_next;
            spike_reg      <= spike_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PULSE_COEF:      coef_reg      <= cfg_wdata[COEF_W-1:0];
                    REG_MIN_WIDTH:       min_width_reg <= cfg_wdata[TICK_W-1:0];
                    REG_TEST_MODE:       test_mode_reg <= cfg_wdata[0];
                    REG_DISTANCE_PRESET: ;   // loads the odometer directly
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        ticks_reg  <= ticks_next;
        glitch_reg <= glitch_next;
        scan_reg   <= scan_next;
        sum_reg    <= sum_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        w_reg      <= w_next;
        prod_reg   <= prod_next;
        if (out_load) begin
            out_speed_reg  <= speed_now_reg;
            out_dist_reg   <= distance_reg;
            out_glitch_reg <= glitch_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_instant_speed  = out_speed_reg;
    assign m_total_distance = out_dist_reg;
    assign m_glitch         = out_glitch_reg;

endmodule

// ===== verif/tb_wheel_pulse_speed_odometer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_pulse_speed_odometer
// Self-checking bench for the wheel pulse speed / odometer block.
// ----------------------------------------------------------------------------
// Pulse and timeout beats go in over a valid/ready channel with random gaps.
// An in-bench predictor tracks the interval ring, arming, spike filter and
// odometer and queues one expected reading per accepted beat. Every result
// beat is checked field by field against the oldest queued reading.
// Phases: directed corner cases, register extremes, spike-filter episodes,
// fast odometer rollover, a stretch with no idling, then random settings.
// ----------------------------------------------------------------------------
module tb_wheel_pulse_speed_odometer;
    import wpso_pkg::*;

    localparam int RING_DEPTH   = WINDOW_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int TOTAL_BEATS  = 950;
    localparam int SETTLE_TAIL  = 150;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [DIST_W-1:0]  odo;
        logic               glitch;
    } reading_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_action = 1'b0;
    logic [TICK_W-1:0]      s_interval_ticks = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SPEED_W-1:0]     m_instant_speed;
    logic [DIST_W-1:0]      m_total_distance;
    logic                   m_glitch;

    // Register shadow and predictor state
    logic [COEF_W-1:0]  cal_coef = COEF_RST;
    logic [TICK_W-1:0]  cal_min_width = MIN_WIDTH_RST;
    logic               cal_test_mode = TEST_MODE_RST;
    logic [TICK_W-1:0]  iv_ring [RING_DEPTH] = '{default: '0};
    int                 iv_slot = 0;
    logic               is_armed = 1'b0;
    logic [31:0]        pulse_backlog = '0;
    logic [DIST_W-1:0]  odo_total = PRESET_RST;
    logic [SPEED_W-1:0] kmh_now = '0;
    logic [SPEED_W-1:0] kmh_last = '0;
    logic [SPIKE_W-1:0] spike_run = '0;

    reading_t pending_readings[$];
    int       mismatch_count = 0;
    int       beats_sent = 0;
    int       quiet_cycles = 0;
    bit       src_idle_en = 1'b1;
    bit       snk_stall_en = 1'b1;

    wheel_pulse_speed_odometer u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_interval_ticks (s_interval_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_instant_speed  (m_instant_speed),
        .m_total_distance (m_total_distance),
        .m_glitch         (m_glitch)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] coef_value();
        return (cal_coef == '0) ? 64'd1 : 64'(cal_coef);
    endfunction

    function automatic void refresh_kmh();
        logic [31:0]        lo, hi, sum, v;
        logic [63:0]        w, q;
        logic [SPEED_W-1:0] s;
        if (!cal_test_mode) begin
            lo = 32'hFFFF;
            hi = '0;
            sum = '0;
            foreach (iv_ring[i]) begin
                v = 32'(iv_ring[i]);
                if (v > hi) hi = v;
                if (v < lo) lo = v;
                sum = sum + v;
            end
            w = 64'((sum - lo - hi) / 32'(RING_DEPTH - 2));
        end else begin
            w = 64'(iv_ring[0]);
        end
        if (w == '0) return;
        q = 64'(SPEED_NUM) / (w * coef_value());
        s = q[SPEED_W-1:0];
        if (!cal_test_mode && s > kmh_last && (s - kmh_last) >= 8'(SPIKE_DELTA)) begin
            // big rise: held back until it persists
            spike_run = spike_run + 1'b1;
            if (spike_run >= 7'(SPIKE_LIMIT)) begin
                spike_run = '0;
                kmh_now = s;
                kmh_last = s;
            end
        end else begin
            if (!cal_test_mode) spike_run = '0;
            kmh_now = s;
            kmh_last = s;
        end
    endfunction

    function automatic reading_t predict_reading(logic act, logic [TICK_W-1:0] ticks);
        reading_t r;
        logic     glitch;
        glitch = 1'b0;
        if (act == ACT_PULSE) begin
            pulse_backlog = pulse_backlog + 1;
            if (!is_armed) begin
                is_armed = 1'b1;
            end else if (ticks >= cal_min_width) begin
                if (64'(pulse_backlog) > coef_value() / 64'(PULSE_DIV)) begin
                    odo_total = odo_total
                        + 32'((64'(pulse_backlog) * 64'(DIST_SCALE)) / coef_value());
                    pulse_backlog = '0;
                end
                if (!cal_test_mode) begin
                    iv_slot = (iv_slot == RING_DEPTH - 1) ? 0 : iv_slot + 1;
                    iv_ring[iv_slot] = ticks;
                end else begin
                    iv_ring[0] = ticks;
                end
            end else begin
                glitch = 1'b1;
                pulse_backlog = pulse_backlog - 1;
            end
            refresh_kmh();
        end else begin
            is_armed = 1'b0;
            kmh_now = '0;
            kmh_last = '0;
            iv_ring = '{default: '0};
            iv_slot = 0;
        end
        r.speed = kmh_now;
        r.odo = odo_total;
        r.glitch = glitch;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : result_check
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("beat with nothing expected: speed %0d dist %0d glitch %0b",
                    m_instant_speed, m_total_distance, m_glitch));
            end else begin
                want = pending_readings.pop_front();
                if (m_instant_speed !== want.speed)
                    report_mismatch($sformatf("instant_speed: expected %0d, got %0d",
                        want.speed, m_instant_speed));
                if (m_total_distance !== want.odo)
                    report_mismatch($sformatf("total_distance: expected %0d, got %0d",
                        want.odo, m_total_distance));
                if (m_glitch !== want.glitch)
                    report_mismatch($sformatf("glitch: expected %0b, got %0b",
                        want.glitch, m_glitch));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready = !snk_stall_en || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (all entered and left at a falling edge)
    // ------------------------------------------------------------------
    task automatic send_beat(input logic act, input logic [TICK_W-1:0] ticks);
        while (src_idle_en && $urandom_range(0, 99) < 18) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = act;
        s_interval_ticks = ticks;
        do @(posedge aclk); while (!s_ready);
        pending_readings.push_back(predict_reading(act, ticks));
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid = 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_PULSE_COEF:      cal_coef = value[COEF_W-1:0];
            REG_MIN_WIDTH:       cal_min_width = value[TICK_W-1:0];
            REG_TEST_MODE:       cal_test_mode = value[0];
            REG_DISTANCE_PRESET: odo_total = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] coef, input logic [31:0] min_w,
                             input logic [31:0] tmode, input logic [31:0] preset);
        wait_for_results();
        write_register(REG_PULSE_COEF, coef);
        write_register(REG_MIN_WIDTH, min_w);
        write_register(REG_TEST_MODE, tmode);
        write_register(REG_DISTANCE_PRESET, preset);
    endtask

    // Pulses jittered around base, with optional glitches and timeouts
    task automatic drive_run(input int unsigned base, input int unsigned len,
                             input int unsigned glitch_pct, input int unsigned timeout_pct);
        int unsigned r, t, spread;
        spread = base / 16;
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < timeout_pct) begin
                send_beat(ACT_TIMEOUT, 16'($urandom));
            end else if (r < timeout_pct + glitch_pct && cal_min_width != '0) begin
                send_beat(ACT_PULSE, 16'($urandom_range(0, cal_min_width - 1)));
            end else begin
                t = base - spread + $urandom_range(0, 2 * spread);
                if (t > 65535) t = 65535;
                if (t < cal_min_width) t = cal_min_width;
                send_beat(ACT_PULSE, 16'(t));
            end
        end
    endtask

    // Mostly well-formed pulse trains, some raw noise
    task automatic drive_episode(input int beats);
        int stop_at, kind;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                drive_run(cal_min_width + $urandom_range(1, 1500), $urandom_range(5, 30), 4, 2);
            else if (kind < 80)
                drive_run(cal_min_width + $urandom_range(0, 60), $urandom_range(4, 12), 35, 5);
            else
                repeat ($urandom_range(3, 10))
                    send_beat(1'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_beat(ACT_TIMEOUT, 16'hFFFF);      // timeout while unarmed
        send_beat(ACT_PULSE, 16'hFFFF);        // arming pulse, no width check
        send_beat(ACT_PULSE, 16'd0);           // glitch
        send_beat(ACT_PULSE, MIN_WIDTH_RST - 1'b1);
        send_beat(ACT_PULSE, MIN_WIDTH_RST);   // exactly min width
        send_beat(ACT_PULSE, 16'hFFFF);        // speed wraps past 8 bits
        repeat (4) send_beat(ACT_PULSE, 16'd40);
        send_beat(ACT_PULSE, 16'd100);
        send_beat(ACT_TIMEOUT, 16'd0);         // timeout while armed
        send_beat(ACT_PULSE, 16'd5);           // arms again, not a glitch
        send_beat(ACT_PULSE, 16'd5);
    endtask

    task automatic test_register_extremes();
        // zero coefficient acts as one, junk above the field widths
        configure(32'hABCD_0000, 32'h5A5A_0000, 32'hFFFF_FFFE | 32'd1, 32'hFFFF_FFFF);
        send_beat(ACT_PULSE, 16'd7);
        send_beat(ACT_PULSE, 16'd0);           // test mode, zero width: speed kept
        send_beat(ACT_PULSE, 16'd1);
        send_beat(ACT_PULSE, 16'hFFFF);
        send_beat(ACT_TIMEOUT, 16'hFFFF);
        configure(32'hFFFF, 32'hFFFF, 32'd0, 32'd0);
        send_beat(ACT_PULSE, 16'd1);
        send_beat(ACT_PULSE, 16'hFFFE);        // glitch at largest min width
        repeat (4) send_beat(ACT_PULSE, 16'hFFFF);
        configure(32'd1, 32'd1, 32'd1, 32'hFFFF_FF00);
        repeat (3) send_beat(ACT_PULSE, 16'($urandom_range(1, 3)));
    endtask

    task automatic test_spike_filter();
        int unsigned slow, fast;
        configure(32'(COEF_RST), 32'(MIN_WIDTH_RST), 32'd0, $urandom);
        for (int k = 0; k < 3; k++) begin
            slow = $urandom_range(200, 1000);
            fast = $urandom_range(60, 100);
            send_beat(ACT_TIMEOUT, '0);
            drive_run(slow, 8, 0, 0);
            // first episode stops just short of the hold-off count
            drive_run(fast, (k == 0) ? 90 : $urandom_range(106, 116), 0, 0);
            drive_run(slow, 6, 0, 0);
        end
    endtask

    task automatic test_odometer_rollover();
        configure($urandom_range(1, 400), $urandom_range(0, 40), 32'd0,
                  32'hFFFF_FF00 | $urandom_range(0, 255));
        drive_episode(150);
    endtask

    task automatic test_back_to_back();
        configure($urandom_range(3000, 12000), $urandom_range(0, 80), 32'd0, $urandom);
        src_idle_en = 1'b0;
        snk_stall_en = 1'b0;
        drive_episode(120);
        wait_for_results();
        src_idle_en = 1'b1;
        snk_stall_en = 1'b1;
    endtask

    task automatic test_random_settings();
        logic [31:0] coef, min_w;
        while (beats_sent < TOTAL_BEATS) begin
            case ($urandom_range(0, 2))
                0:       coef = $urandom_range(1, 65535);
                1:       coef = $urandom_range(3000, 12000);
                default: coef = $urandom_range(1, 200);
            endcase
            min_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 200);
            configure(coef, min_w, $urandom_range(0, 1), $urandom);
            drive_episode(60);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_register_extremes();
        test_spike_filter();
        test_odometer_rollover();
        test_back_to_back();
        test_random_settings();

        wait_for_results();
        repeat (SETTLE_TAIL) @(posedge aclk);
        if (mismatch_count == 0 && pending_readings.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
